// ===== hdl/llt_pkg.sv =====
package llt_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int KEY_BITS_DEF    = 32;
  localparam int AGENT_BITS_DEF  = 8;

  localparam int TIME_W   = 32;
  localparam int CFG_W    = 32;
  localparam int PADDR_W  = 3;

  localparam logic [CFG_W-1:0] STALE_WINDOW_RST = 32'd30000;

  // register index, taken from paddr[2]
  localparam logic REG_STALE_WINDOW = 1'b0;

  localparam logic [1:0] MODE_ACQUIRE = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_CHECK   = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  localparam logic [2:0] ST_SUCCESS  = 3'd0;
  localparam logic [2:0] ST_MINE     = 3'd1;
  localparam logic [2:0] ST_OTHER    = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_NOTOWNED = 3'd5;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] resource_key;
    logic [7:0]  agent_id;
    logic [31:0] now_time;
    logic        last_in_txn;
  } req_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] status;
    logic       txn_all_ok;
  } resp_t;

endpackage

// ===== hdl/llt_table.sv =====
module llt_table import llt_pkg::*; #(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  parameter int WIDTH = KEY_BITS_DEF + AGENT_BITS_DEF + TIME_W,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/llt_engine.sv =====
module llt_engine import llt_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int AGENT_BITS  = AGENT_BITS_DEF,
  localparam int IDX_W = $clog2(TABLE_DEPTH),
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
  localparam int ENT_W = KEY_BITS + AGENT_BITS + TIME_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CFG_W-1:0] stale_window,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req_data,
  output logic             resp_valid,
  input  logic             resp_stall,
  output resp_t            resp_data,
  output logic             mem_we,
  output logic [IDX_W-1:0] mem_waddr,
  output logic [ENT_W-1:0] mem_wdata,
  output logic             mem_re,
  output logic [IDX_W-1:0] mem_raddr,
  input  logic [ENT_W-1:0] mem_rdata
);

  typedef enum logic [1:0] {IDLE, SCAN, FINISH} state_t;

  state_t                state;
  req_t                  req;
  logic [KEY_BITS-1:0]   key;
  logic [AGENT_BITS-1:0] agent;
  logic [CNT_W-1:0]      issue_cnt;
  logic                  rd_vld;
  logic [IDX_W-1:0]      rd_ptr;
  logic                  hit;
  logic [AGENT_BITS-1:0] hit_owner;
  logic [CNT_W-1:0]      used_count;
  logic                  txn_accum;

  logic [KEY_BITS-1:0]   ent_key;
  logic [AGENT_BITS-1:0] ent_owner;
  logic [TIME_W-1:0]     ent_time;
  logic [TIME_W-1:0]     age;
  logic                  stale;
  logic                  live_raw;
  logic                  key_match;
  logic                  own_match;
  logic                  issue;
  logic                  scan_done;
  logic                  full;
  logic                  slot_free;
  logic                  commit;
  logic                  append;
  logic                  stale_wr;
  logic                  rel_wr;
  resp_t                 result;
  logic                  txn_next;

  assign ent_key   = mem_rdata[ENT_W-1 -: KEY_BITS];
  assign ent_owner = mem_rdata[TIME_W +: AGENT_BITS];
  assign ent_time  = mem_rdata[TIME_W-1:0];

  // wraps mod 2^32, so a clock that went backwards looks old
  assign age       = req.now_time - ent_time;
  assign stale     = age > stale_window;
  assign live_raw  = ent_owner != '0;
  assign key_match = ent_key == key;
  assign own_match = ent_owner == agent;

  assign issue     = (state == SCAN) && (issue_cnt != used_count);
  assign scan_done = (state == SCAN) && !issue && !rd_vld;
  assign full      = used_count == CNT_W'(TABLE_DEPTH);
  assign slot_free = !resp_valid || !resp_stall;
  assign commit    = (state == FINISH) && slot_free;
  assign append    = commit && (req.mode == MODE_ACQUIRE) && !full && !hit;

  assign stale_wr  = rd_vld && (req.mode == MODE_ACQUIRE) && stale;
  assign rel_wr    = rd_vld && (req.mode == MODE_RELEASE) && !hit && live_raw
                     && key_match && own_match;

  assign mem_we    = stale_wr || rel_wr || append;
  assign mem_waddr = append ? used_count[IDX_W-1:0] : rd_ptr;
  assign mem_wdata = append ? {key, agent, req.now_time}
                            : {ent_key, {AGENT_BITS{1'b0}}, ent_time};
  assign mem_re    = issue;
  assign mem_raddr = issue_cnt[IDX_W-1:0];

  assign req_stall = state != IDLE;

  always_comb begin
    result   = '0;
    txn_next = txn_accum;
    case (req.mode)
      MODE_ACQUIRE: begin
        if (full) begin
          result.status = ST_FULL;
        end else if (hit) begin
          result.ok     = hit_owner == agent;
          result.status = (hit_owner == agent) ? ST_MINE : ST_OTHER;
        end else begin
          result.ok     = 1'b1;
          result.status = ST_SUCCESS;
        end
      end
      MODE_RELEASE: begin
        result.ok     = hit;
        result.status = hit ? ST_SUCCESS : ST_NOTFOUND;
      end
      MODE_CHECK: begin
        result.ok         = hit;
        result.status     = hit ? ST_SUCCESS : ST_NOTOWNED;
        result.txn_all_ok = txn_accum & hit;
        txn_next          = req.last_in_txn ? 1'b1 : (txn_accum & hit);
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      used_count <= '0;
      txn_accum  <= 1'b1;
      resp_valid <= 1'b0;
      rd_vld     <= 1'b0;
    end else begin
      if (resp_valid && !resp_stall && !commit) begin
        resp_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          rd_vld <= 1'b0;
          if (req_valid) begin
            req       <= req_data;
            key       <= KEY_BITS'(req_data.resource_key);
            agent     <= AGENT_BITS'(req_data.agent_id);
            hit       <= 1'b0;
            issue_cnt <= '0;
            if (req_data.mode == MODE_NONE || (req_data.mode == MODE_ACQUIRE && full)) begin
              state <= FINISH;
            end else begin
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          rd_vld <= issue;
          if (issue) begin
            issue_cnt <= issue_cnt + 1'b1;
            rd_ptr    <= issue_cnt[IDX_W-1:0];
          end
          if (rd_vld) begin
            case (req.mode)
              MODE_ACQUIRE: begin
                // stale entries are freed on the same pass that looks for the key
                if (!hit && live_raw && !stale && key_match) begin
                  hit       <= 1'b1;
                  hit_owner <= ent_owner;
                end
              end
              MODE_RELEASE: begin
                if (rel_wr) begin
                  hit <= 1'b1;
                end
              end
              MODE_CHECK: begin
                if (live_raw && key_match && own_match) begin
                  hit <= 1'b1;
                end
              end
              default: begin
                hit <= hit;
              end
            endcase
          end
          if (scan_done) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          rd_vld <= 1'b0;
          if (slot_free) begin
            resp_valid <= 1'b1;
            resp_data  <= result;
            txn_accum  <= txn_next;
            if (append) begin
              used_count <= used_count + 1'b1;
            end
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CNT_W'(TABLE_DEPTH))
    else $error("used_count above table depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    used_count != $past(used_count) |-> used_count == $past(used_count) + 1'b1)
    else $error("used_count moved by other than one");

  a_no_same_entry: assert property (@(posedge clk) disable iff (rst)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("write and read of the same entry in one cycle");

  a_rd_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> state == SCAN)
    else $error("read data outside scan");

  a_append_not_full: assert property (@(posedge clk) disable iff (rst)
    append |-> !full)
    else $error("append into a full table");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    resp_valid |-> resp_data.status <= ST_NOTOWNED)
    else $error("status code out of range");

endmodule

// ===== hdl/lease_lock_table.sv =====
// Lease lock table. Each request walks the used part of the table through the
// single read port of the entry memory, one entry per clock. A request passes
// from IDLE through SCAN to FINISH and back to IDLE before the next can be
// accepted; an acquire into a full table and an unused mode skip SCAN. An
// acquire that scans frees stale entries (age above stale_window, mod 2^32)
// on the same pass that looks up the key; freed slots are not reused, and once
// TABLE_DEPTH entries have been appended every acquire reports full. The entry
// memory is not cleared at reset: only entries below used_count are ever read.
// One result per request; a finished result sits in an output register so the
// next request can start while it waits. stale_window is at byte address 0 and
// resets to 30000.
module lease_lock_table import llt_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int AGENT_BITS  = AGENT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_t               req_data,
  output logic               resp_valid,
  input  logic               resp_stall,
  output resp_t              resp_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]   pwdata,
  output logic [CFG_W-1:0]   prdata,
  output logic               pready
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int ENT_W = KEY_BITS + AGENT_BITS + TIME_W;

  logic [CFG_W-1:0] stale_window;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ENT_W-1:0] mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [ENT_W-1:0] mem_rdata;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[PADDR_W-1] == REG_STALE_WINDOW;
  assign prdata  = reg_sel ? stale_window : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_window <= STALE_WINDOW_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      stale_window <= pwdata;
    end
  end

  llt_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .AGENT_BITS  (AGENT_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .stale_window (stale_window),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_data     (req_data),
    .resp_valid   (resp_valid),
    .resp_stall   (resp_stall),
    .resp_data    (resp_data),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  llt_table #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENT_W)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
